>>> sv/rtd_one_shot_conversion_sequencer_unit_macros.svh
`ifndef RTD_ONE_SHOT_CONVERSION_SEQUENCER_UNIT_MACROS_SVH
`define RTD_ONE_SHOT_CONVERSION_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RTD_OSCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RTD_OSCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rtd_oscs_pkg.sv
`default_nettype none

package rtd_oscs_pkg;

   localparam int TICK_W = 16;
   localparam int CODE_W = 15;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_DONE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] CSR_SETTLE  = 2'd0;
   localparam logic [1:0] CSR_CONVERT = 2'd1;
   localparam logic [1:0] CSR_NFS     = 2'd2;

   localparam logic [TICK_W-1:0] SETTLE_RESET  = 16'd10;
   localparam logic [TICK_W-1:0] CONVERT_RESET = 16'd65;
   localparam logic [CODE_W-1:0] NFS_RESET     = 15'd32760;

   localparam logic       KIND_REQ = 1'b0;
   localparam logic       KIND_REP = 1'b1;
   localparam logic [1:0] LEN_SHORT = 2'd2;
   localparam logic [1:0] LEN_LONG  = 2'd3;

   localparam logic [7:0] ADDR_WRITE = 8'h80;
   localparam logic [7:0] REG_CFG    = 8'h00;
   localparam logic [7:0] REG_RTD    = 8'h01;
   localparam logic [7:0] REG_FAULTS = 8'h07;
   localparam logic [7:0] CFG_REST   = 8'h01;
   localparam logic [7:0] CFG_BIAS   = 8'h81;
   localparam logic [7:0] CFG_SHOT   = 8'hA1;
   localparam logic [7:0] CFG_FCLR   = 8'h03;
   localparam logic [7:0] SHOT_BIT   = 8'h20;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_PROBE_W    = 3'd1;
   localparam logic [2:0] ST_PROBE_R    = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [2:0] ST_BIAS_ON    = 3'd4;
   localparam logic [2:0] ST_SHOT       = 3'd5;
   localparam logic [2:0] ST_READ       = 3'd6;
   localparam logic [2:0] ST_BIAS_OFF   = 3'd7;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_PROBE_W,
      PH_PROBE_R,
      PH_BIAS_ON,
      PH_SETTLE,
      PH_SHOT,
      PH_CONVERT,
      PH_READ,
      PH_OFF_OK,
      PH_OFF_SAT,
      PH_FAULT_R,
      PH_FAULT_CLR,
      PH_RECOVER
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] settle_ticks;
      logic [TICK_W-1:0] conversion_ticks;
      logic [CODE_W-1:0] near_full_scale;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [1:0]        tx_len;
      logic [7:0]        tx_addr;
      logic [7:0]        tx_data;
      logic [2:0]        status;
      logic              reading_valid;
      logic              over_range;
      logic [CODE_W-1:0] rtd_code;
      logic [7:0]        fault_reg;
   } rsp_type;

   function automatic rsp_type make_req(logic [1:0] len, logic [7:0] addr, logic [7:0] data);
      rsp_type r;
      r         = '0;
      r.kind    = KIND_REQ;
      r.tx_len  = len;
      r.tx_addr = addr;
      r.tx_data = data;
      return r;
   endfunction

   function automatic rsp_type make_rep(logic [2:0] st, logic valid, logic oor,
                                        logic [CODE_W-1:0] code, logic [7:0] faults);
      rsp_type r;
      r               = '0;
      r.kind          = KIND_REP;
      r.status        = st;
      r.reading_valid = valid;
      r.over_range    = oor;
      r.rtd_code      = code;
      r.fault_reg     = faults;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/rtd_oscs_ifs.sv
`default_nettype none

interface rtd_oscs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic       xfer_ok;
   logic [7:0] rx_first;
   logic [7:0] rx_second;

   modport source (output valid, opcode, xfer_ok, rx_first, rx_second, input ready);
   modport sink (input valid, opcode, xfer_ok, rx_first, rx_second, output ready);
endinterface

interface rtd_oscs_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [1:0]  tx_len;
   logic [7:0]  tx_addr;
   logic [7:0]  tx_data;
   logic [2:0]  status;
   logic        reading_valid;
   logic        over_range;
   logic [14:0] rtd_code;
   logic [7:0]  fault_reg;

   modport source (output valid, kind, tx_len, tx_addr, tx_data, status, reading_valid,
                   over_range, rtd_code, fault_reg, input ready);
   modport sink (input valid, kind, tx_len, tx_addr, tx_data, status, reading_valid,
                 over_range, rtd_code, fault_reg, output ready);
endinterface

`default_nettype wire

>>> sv/rtd_oscs_csr.sv
`default_nettype none

module rtd_oscs_csr
   import rtd_oscs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_addr,
   input  wire logic [TICK_W-1:0] csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SETTLE:  cfg_in.settle_ticks = csr_wdata;
            CSR_CONVERT: cfg_in.conversion_ticks = csr_wdata;
            CSR_NFS:     cfg_in.near_full_scale = csr_wdata[CODE_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks     <= SETTLE_RESET;
         cfg_ff.conversion_ticks <= CONVERT_RESET;
         cfg_ff.near_full_scale  <= NFS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/rtd_oscs_seq.sv
`default_nettype none

module rtd_oscs_seq
   import rtd_oscs_pkg::*;
#(
   parameter int WAIT_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [1:0] opcode,
   input  wire logic       xfer_ok,
   input  wire logic [7:0] rx_first,
   input  wire logic [7:0] rx_second,
   input  wire cfg_type    cfg,
   output logic            emit,
   output rsp_type         result
);

   localparam int EXT_W = (WAIT_BITS > TICK_W) ? WAIT_BITS : TICK_W;
   localparam logic [EXT_W-1:0] WAIT_MAX = EXT_W'({WAIT_BITS{1'b1}});

   phase_type             phase_ff, phase_in;
   logic [WAIT_BITS-1:0]  wait_count_ff, wait_count_in;
   logic [CODE_W-1:0]     held_code_ff, held_code_in;
   logic [7:0]            held_faults_ff, held_faults_in;
   logic [2:0]            pending_status_ff, pending_status_in;

   logic [EXT_W-1:0]      settle_ext, convert_ext;
   logic [WAIT_BITS-1:0]  settle_load, convert_load;
   logic [CODE_W-1:0]     read_code;
   logic                  read_sat;

   assign settle_ext   = EXT_W'(cfg.settle_ticks);
   assign convert_ext  = EXT_W'(cfg.conversion_ticks);
   assign settle_load  = (settle_ext > WAIT_MAX) ? WAIT_BITS'(WAIT_MAX) : WAIT_BITS'(settle_ext);
   assign convert_load = (convert_ext > WAIT_MAX) ? WAIT_BITS'(WAIT_MAX)
                                                  : WAIT_BITS'(convert_ext);
   assign read_code    = {rx_first, rx_second[7:1]};
   assign read_sat     = rx_second[0] || (read_code >= cfg.near_full_scale);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         wait_count_ff     <= '0;
         held_code_ff      <= '0;
         held_faults_ff    <= '0;
         pending_status_ff <= ST_OK;
      end else begin
         phase_ff          <= phase_in;
         wait_count_ff     <= wait_count_in;
         held_code_ff      <= held_code_in;
         held_faults_ff    <= held_faults_in;
         pending_status_ff <= pending_status_in;
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      wait_count_in     = wait_count_ff;
      held_code_in      = held_code_ff;
      held_faults_in    = held_faults_ff;
      pending_status_in = pending_status_ff;
      emit              = 1'b0;
      result            = '0;
      if (fire) begin
         case (opcode)
            OP_START: begin
               if (phase_ff == PH_IDLE) begin
                  held_code_in      = '0;
                  held_faults_in    = '0;
                  pending_status_in = ST_OK;
                  phase_in          = PH_PROBE_W;
                  emit              = 1'b1;
                  result            = make_req(LEN_SHORT, REG_CFG | ADDR_WRITE, CFG_REST);
               end
            end
            OP_TICK: begin
               if (phase_ff == PH_SETTLE || phase_ff == PH_CONVERT) begin
                  if (wait_count_ff > WAIT_BITS'(1)) begin
                     wait_count_in = wait_count_ff - WAIT_BITS'(1);
                  end else begin
                     wait_count_in = '0;
                     emit          = 1'b1;
                     if (phase_ff == PH_SETTLE) begin
                        phase_in = PH_SHOT;
                        result   = make_req(LEN_SHORT, REG_CFG | ADDR_WRITE, CFG_SHOT);
                     end else begin
                        phase_in = PH_READ;
                        result   = make_req(LEN_LONG, REG_RTD, 8'h00);
                     end
                  end
               end
            end
            OP_DONE: begin
               case (phase_ff)
                  PH_PROBE_W: begin
                     emit = 1'b1;
                     if (!xfer_ok) begin
                        phase_in = PH_IDLE;
                        result   = make_rep(ST_PROBE_W, 1'b0, 1'b0, '0, 8'h00);
                     end else begin
                        phase_in = PH_PROBE_R;
                        result   = make_req(LEN_SHORT, REG_CFG, 8'h00);
                     end
                  end
                  PH_PROBE_R: begin
                     emit = 1'b1;
                     if (!xfer_ok) begin
                        phase_in = PH_IDLE;
                        result   = make_rep(ST_PROBE_R, 1'b0, 1'b0, '0, 8'h00);
                     end else if ((rx_first & ~SHOT_BIT) != CFG_REST) begin
                        phase_in = PH_IDLE;
                        result   = make_rep(ST_NOT_FOUND, 1'b0, 1'b0, '0, 8'h00);
                     end else begin
                        phase_in = PH_BIAS_ON;
                        result   = make_req(LEN_SHORT, REG_CFG | ADDR_WRITE, CFG_BIAS);
                     end
                  end
                  PH_BIAS_ON: begin
                     if (!xfer_ok) begin
                        emit     = 1'b1;
                        phase_in = PH_IDLE;
                        result   = make_rep(ST_BIAS_ON, 1'b0, 1'b0, '0, 8'h00);
                     end else begin
                        wait_count_in = settle_load;
                        if (settle_load == '0) begin
                           emit     = 1'b1;
                           phase_in = PH_SHOT;
                           result   = make_req(LEN_SHORT, REG_CFG | ADDR_WRITE, CFG_SHOT);
                        end else begin
                           phase_in = PH_SETTLE;
                        end
                     end
                  end
                  PH_SHOT: begin
                     if (!xfer_ok) begin
                        emit              = 1'b1;
                        pending_status_in = ST_SHOT;
                        phase_in          = PH_RECOVER;
                        result = make_req(LEN_SHORT, REG_CFG | ADDR_WRITE, CFG_REST);
                     end else begin
                        wait_count_in = convert_load;
                        if (convert_load == '0) begin
                           emit     = 1'b1;
                           phase_in = PH_READ;
                           result   = make_req(LEN_LONG, REG_RTD, 8'h00);
                        end else begin
                           phase_in = PH_CONVERT;
                        end
                     end
                  end
                  PH_READ: begin
                     emit   = 1'b1;
                     result = make_req(LEN_SHORT, REG_CFG | ADDR_WRITE, CFG_REST);
                     if (!xfer_ok) begin
                        pending_status_in = ST_READ;
                        phase_in          = PH_RECOVER;
                     end else begin
                        held_code_in   = read_code;
                        held_faults_in = '0;
                        phase_in       = read_sat ? PH_OFF_SAT : PH_OFF_OK;
                     end
                  end
                  PH_OFF_OK, PH_OFF_SAT: begin
                     emit = 1'b1;
                     if (!xfer_ok) begin
                        phase_in = PH_IDLE;
                        result   = make_rep(ST_BIAS_OFF, 1'b0, 1'b0, '0, 8'h00);
                     end else if (phase_ff == PH_OFF_OK) begin
                        phase_in = PH_IDLE;
                        result   = make_rep(ST_OK, 1'b1, 1'b0, held_code_ff, 8'h00);
                     end else begin
                        phase_in = PH_FAULT_R;
                        result   = make_req(LEN_SHORT, REG_FAULTS, 8'h00);
                     end
                  end
                  PH_FAULT_R: begin
                     emit           = 1'b1;
                     held_faults_in = xfer_ok ? rx_first : 8'h00;
                     phase_in       = PH_FAULT_CLR;
                     result         = make_req(LEN_SHORT, REG_CFG | ADDR_WRITE, CFG_FCLR);
                  end
                  PH_FAULT_CLR: begin
                     emit     = 1'b1;
                     phase_in = PH_IDLE;
                     result   = make_rep(ST_OK, 1'b0, 1'b1, held_code_ff, held_faults_ff);
                  end
                  PH_RECOVER: begin
                     emit     = 1'b1;
                     phase_in = PH_IDLE;
                     result   = make_rep(pending_status_ff, 1'b0, 1'b0, '0, 8'h00);
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> sv/rtd_oscs_outreg.sv
`default_nettype none

module rtd_oscs_outreg
   import rtd_oscs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type data,
   input  wire logic    take,
   output logic         slot_free,
   output logic         held_valid,
   output rsp_type      held_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign slot_free = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

`default_nettype wire

>>> sv/rtd_one_shot_conversion_sequencer_unit.sv
// Latency: a result is registered at the edge that accepts its item and is shown the next cycle.
// Throughput: one item per cycle while the input is not stalled; the sequencer state updates in a single pass.
// The input is stalled only while a result waits in the output register and is not taken.
// Reset (synchronous, active high) returns the sequencer to idle, empties the output
// register and loads the register defaults: settle 10, conversion 65, full scale 32760.
`default_nettype none

module rtd_one_shot_conversion_sequencer_unit
   import rtd_oscs_pkg::*;
#(
   parameter int WAIT_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   rtd_oscs_req_if.sink           req_bus,
   rtd_oscs_rsp_if.source         rsp_bus,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_addr,
   input  wire logic [TICK_W-1:0] csr_wdata
);

   cfg_type cfg;
   rsp_type result, held_data;
   logic    emit, fire, slot_free, held_valid;

   assign fire          = req_bus.valid && slot_free;
   assign req_bus.ready = slot_free;

   rtd_oscs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rtd_oscs_seq #(
      .WAIT_BITS (WAIT_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .opcode    (req_bus.opcode),
      .xfer_ok   (req_bus.xfer_ok),
      .rx_first  (req_bus.rx_first),
      .rx_second (req_bus.rx_second),
      .cfg       (cfg),
      .emit      (emit),
      .result    (result)
   );

   rtd_oscs_outreg u_outreg (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .data       (result),
      .take       (rsp_bus.ready),
      .slot_free  (slot_free),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   assign rsp_bus.valid         = held_valid;
   assign rsp_bus.kind          = held_data.kind;
   assign rsp_bus.tx_len        = held_data.tx_len;
   assign rsp_bus.tx_addr       = held_data.tx_addr;
   assign rsp_bus.tx_data       = held_data.tx_data;
   assign rsp_bus.status        = held_data.status;
   assign rsp_bus.reading_valid = held_data.reading_valid;
   assign rsp_bus.over_range    = held_data.over_range;
   assign rsp_bus.rtd_code      = held_data.rtd_code;
   assign rsp_bus.fault_reg     = held_data.fault_reg;

endmodule

`default_nettype wire

>>> sv/rtd_oscs_checker.sv
`default_nettype none

`include "rtd_one_shot_conversion_sequencer_unit_macros.svh"

module rtd_oscs_checker
   import rtd_oscs_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_kind,
   input wire logic [1:0]        rsp_tx_len,
   input wire logic [7:0]        rsp_tx_addr,
   input wire logic [7:0]        rsp_tx_data,
   input wire logic [2:0]        rsp_status,
   input wire logic              rsp_reading_valid,
   input wire logic              rsp_over_range,
   input wire logic [CODE_W-1:0] rsp_rtd_code,
   input wire logic [7:0]        rsp_fault_reg
);

   logic [46:0] rsp_payload;
   logic        req_payload_clean;
   logic        rep_payload_clean;

   assign rsp_payload = {rsp_kind, rsp_tx_len, rsp_tx_addr, rsp_tx_data, rsp_status,
                         rsp_reading_valid, rsp_over_range, rsp_rtd_code, rsp_fault_reg};
   assign req_payload_clean = (rsp_tx_len == LEN_SHORT || rsp_tx_len == LEN_LONG)
                              && rsp_status == ST_OK && !rsp_reading_valid
                              && !rsp_over_range && rsp_rtd_code == '0
                              && rsp_fault_reg == 8'h00;
   assign rep_payload_clean = rsp_tx_len == 2'd0 && rsp_tx_addr == 8'h00
                              && rsp_tx_data == 8'h00
                              && !(rsp_reading_valid && rsp_over_range);

   `RTD_OSCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "Stalled result changed or dropped.")
   `RTD_OSCS_ASSERT_NOW(a_free_slot_ready, clock, reset, req_valid && !rsp_valid, req_ready, "Input stalled with an empty output register.")
   `RTD_OSCS_ASSERT_NOW(a_req_fields, clock, reset, rsp_valid && rsp_kind == KIND_REQ, req_payload_clean, "Transfer request carries report fields.")
   `RTD_OSCS_ASSERT_NOW(a_rep_fields, clock, reset, rsp_valid && rsp_kind == KIND_REP, rep_payload_clean, "Report carries request fields or conflicting flags.")
   `RTD_OSCS_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "Result shown right after reset.")

endmodule

bind rtd_one_shot_conversion_sequencer_unit rtd_oscs_checker u_rtd_oscs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_kind          (rsp_bus.kind),
   .rsp_tx_len        (rsp_bus.tx_len),
   .rsp_tx_addr       (rsp_bus.tx_addr),
   .rsp_tx_data       (rsp_bus.tx_data),
   .rsp_status        (rsp_bus.status),
   .rsp_reading_valid (rsp_bus.reading_valid),
   .rsp_over_range    (rsp_bus.over_range),
   .rsp_rtd_code      (rsp_bus.rtd_code),
   .rsp_fault_reg     (rsp_bus.fault_reg)
);

`default_nettype wire
